/* design/isothermal_lens_shear_deflection_defines.svh */
// Assertion helpers for the block's top-level RTL file.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef ISOTHERMAL_LENS_SHEAR_DEFLECTION_DEFINES_SVH
`define ISOTHERMAL_LENS_SHEAR_DEFLECTION_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define ILSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ILSD_IMPLY(lbl, ante, cons, msg) \
  `ILSD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* design/ilsd_pkg.sv */
// ----------------------------------------------------------------------------
// ilsd_pkg
// Widths, codes and sideband types of the isothermal lens evaluator.
// ----------------------------------------------------------------------------
package ilsd_pkg;

  // Number format of all ports
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Derived datapath widths
  localparam int MAG_W  = WORD_BITS;                  // |x|, |y|
  localparam int E_W    = WORD_BITS - 1;              // unsigned radii
  localparam int K_W    = 2 * WORD_BITS;              // core^2 + x^2 + y^2
  localparam int SQ_W   = WORD_BITS;                  // floor(sqrt(K))
  localparam int A_W    = 2 * WORD_BITS - 1;          // Jacobian numerators
  localparam int PROD_W = 2 * WORD_BITS;              // signed shear products
  localparam int SH_W   = 2 * WORD_BITS - FRAC_BITS + 1;
  localparam int NUM_W  = E_W + A_W + FRAC_BITS;
  localparam int DEN_W  = K_W + SQ_W;
  localparam int Q_W    = 2 * WORD_BITS - FRAC_BITS;  // quotient cap is 2^Q_W
  localparam int SUM_W  = Q_W + 4;
  localparam int LANES  = 5;

  // Division lanes, in output order
  localparam int L_DX = 0;
  localparam int L_DY = 1;
  localparam int L_XX = 2;
  localparam int L_XY = 3;
  localparam int L_YY = 4;

  // Register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CORE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SING = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Sideband that rides along the final stages
  typedef struct packed {
    logic signed [SH_W-1:0] sh_x;
    logic signed [SH_W-1:0] sh_y;
    logic                   neg_x;
    logic                   neg_y;
    logic                   sing;
  } fin_side_t;

  // Sideband that rides along the square root
  typedef struct packed {
    logic [K_W-1:0]   kk;
    logic [A_W-1:0]   a_xx;
    logic [A_W-1:0]   a_yy;
    logic [A_W-1:0]   a_xy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    fin_side_t        fin;
  } sqrt_side_t;

endpackage

/* design/ilsd_sqrt.sv */
// ----------------------------------------------------------------------------
// ilsd_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ilsd_sqrt import ilsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [K_W-1:0]   rad_i,
  input  sqrt_side_t       side_i,
  output logic             valid_o,
  output logic [SQ_W-1:0]  root_o,
  output sqrt_side_t       side_o
);

  localparam int STG = K_W / 2;

  logic [STG-1:0] vld_q;
  logic [K_W-1:0] rem_q  [STG];
  logic [K_W-1:0] res_q  [STG];
  sqrt_side_t     side_q [STG];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STG-2:0], valid_i};
    end
  end

  for (genvar g = 0; g < STG; g++) begin : g_stage
    localparam logic [K_W-1:0] BIT = {{(K_W-1){1'b0}}, 1'b1} << (K_W - 2 - 2 * g);
    logic [K_W-1:0] rem_in, res_in, trial, rem_d, res_d;
    sqrt_side_t     side_in;

    if (g == 0) begin : g_first
      assign rem_in  = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign res_in  = res_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Try one root bit: subtract when the trial fits
    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + BIT;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        res_q[g]  <= res_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[STG-1];
  assign root_o  = res_q[STG-1][SQ_W-1:0];
  assign side_o  = side_q[STG-1];

endmodule

/* design/ilsd_div.sv */
// ----------------------------------------------------------------------------
// ilsd_div
// Pipelined restoring divider over parallel lanes, quotient capped at 2^Q_W.
// ----------------------------------------------------------------------------
module ilsd_div import ilsd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]  num_i,
  input  logic [LANES-1:0][DEN_W-1:0]  den_i,
  input  fin_side_t                    side_i,
  output logic                         valid_o,
  output logic [LANES-1:0][Q_W:0]      quo_o,
  output fin_side_t                    side_o
);

  localparam int R_W = DEN_W + Q_W;
  localparam int STG = Q_W + 1;

  logic [STG-1:0]                vld_q;
  logic [LANES-1:0][R_W-1:0]     rem_q  [STG];
  logic [LANES-1:0][DEN_W-1:0]   den_q  [STG];
  logic [LANES-1:0][Q_W:0]       quo_q  [STG];
  fin_side_t                     side_q [STG];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STG-2:0], valid_i};
    end
  end

  for (genvar g = 0; g < STG; g++) begin : g_stage
    localparam int SH = Q_W - g;
    logic [LANES-1:0][R_W-1:0]   rem_in, rem_d, dsh;
    logic [LANES-1:0][DEN_W-1:0] den_in;
    logic [LANES-1:0][Q_W:0]     quo_in, quo_d;
    fin_side_t                   side_in;

    if (g == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = {{(R_W-NUM_W){1'b0}}, num_i[l]};
      end
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign den_in  = den_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Take one quotient bit in each lane
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int l = 0; l < LANES; l++) begin
        dsh[l] = {{(R_W-DEN_W){1'b0}}, den_in[l]} << SH;
        if (rem_in[l] >= dsh[l]) begin
          rem_d[l]     = rem_in[l] - dsh[l];
          quo_d[l][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        den_q[g]  <= den_in;
        quo_q[g]  <= quo_d;
        side_q[g] <= side_in;
      end
    end
  end

  // Clamp a quotient that reached the cap
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = quo_q[STG-1][l][Q_W] ? {1'b1, {Q_W{1'b0}}} : quo_q[STG-1][l];
    end
  end

  assign valid_o = vld_q[STG-1];
  assign side_o  = side_q[STG-1];

endmodule

/* design/isothermal_lens_shear_deflection.sv */
// ----------------------------------------------------------------------------
// isothermal_lens_shear_deflection
// Deflection and Jacobian of a cored isothermal sphere lens with shear.
//
// Requests enter on the in channel (pos_x_i, pos_y_i, valid/ready) and
// results leave on the out channel, one result per request, in order.
// Registers core radius, Einstein radius and the two shear terms are
// written on the cfg channel, always ready; the user must do so only while
// no request is in flight, which the block does not enforce. Throughput is
// one request per cycle when not stalled, through the 32-step square root,
// the 49-step divider chain and the multiply, sum and saturate stages.
// A stalled receiver holds the output register; the pipeline behind it
// keeps moving only until the stage in front of the output register holds
// a result, and in_ready_o drops while that stage holds a result that
// cannot move on.
// Reset empties the pipeline and loads the register reset values.
// Status reads 1 when K is zero (all outputs zero), 2 when a value clamped.
// ----------------------------------------------------------------------------
`include "isothermal_lens_shear_deflection_defines.svh"

module isothermal_lens_shear_deflection import ilsd_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [WORD_BITS-1:0]        cfg_data_i,
  // requests
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [WORD_BITS-1:0] pos_x_i,
  input  logic signed [WORD_BITS-1:0] pos_y_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] deflect_x_o,
  output logic signed [WORD_BITS-1:0] deflect_y_o,
  output logic signed [WORD_BITS-1:0] jac_xx_o,
  output logic signed [WORD_BITS-1:0] jac_xy_o,
  output logic signed [WORD_BITS-1:0] jac_yy_o,
  output logic [1:0]                  status_o
);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  // Truncate a Q2F product toward zero to QF
  function automatic logic signed [SH_W-2:0] trunc_q(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    b = p + (p[PROD_W-1] ? {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0);
    return b[PROD_W-1:FRAC_BITS];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [E_W-1:0]              core_q, einstein_q;
  logic signed [WORD_BITS-1:0] shear_cos_q, shear_sin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_q      <= '0;
      einstein_q  <= {{(E_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
      shear_cos_q <= '0;
      shear_sin_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CORE: core_q      <= cfg_data_i[E_W-1:0];
        REG_EIN:  einstein_q  <= cfg_data_i[E_W-1:0];
        REG_COS:  shear_cos_q <= cfg_data_i;
        REG_SIN:  shear_sin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: the output register parts the two sides
  // --------------------------------------------------------------------------
  logic out_en, en, f1_v_q, out_v_q;

  assign out_en     = !out_v_q || out_ready_i;
  assign en         = out_en || !f1_v_q;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Stage 1: magnitudes and signs
  // --------------------------------------------------------------------------
  logic                        s1_v_q;
  logic signed [WORD_BITS-1:0] x_q, y_q;
  logic [MAG_W-1:0]            ax_q, ay_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= pos_x_i;
      y_q  <= pos_y_i;
      ax_q <= pos_x_i[WORD_BITS-1] ? (~pos_x_i + 1'b1) : pos_x_i;
      ay_q <= pos_y_i[WORD_BITS-1] ? (~pos_y_i + 1'b1) : pos_y_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares and shear products
  // --------------------------------------------------------------------------
  logic                     s2_v_q;
  logic [2*MAG_W-1:0]       axx_q, ayy_q, axy_q;
  logic [2*E_W-1:0]         cc_q;
  logic signed [PROD_W-1:0] pcx_q, psy_q, psx_q, pcy_q;
  logic [MAG_W-1:0]         ax2_q, ay2_q;
  logic                     nx2_q, ny2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      axx_q <= ax_q * ax_q;
      ayy_q <= ay_q * ay_q;
      axy_q <= ax_q * ay_q;
      cc_q  <= core_q * core_q;
      pcx_q <= shear_cos_q * x_q;
      psy_q <= shear_sin_q * y_q;
      psx_q <= shear_sin_q * x_q;
      pcy_q <= shear_cos_q * y_q;
      ax2_q <= ax_q;
      ay2_q <= ay_q;
      nx2_q <= x_q[WORD_BITS-1];
      ny2_q <= y_q[WORD_BITS-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: K, Jacobian numerators and shear sums
  // --------------------------------------------------------------------------
  logic                   s3_v_q;
  logic [K_W-1:0]         kk_q;
  logic [A_W-1:0]         a_xx_q, a_yy_q, a_xy_q;
  logic [MAG_W-1:0]       ax3_q, ay3_q;
  logic signed [SH_W-1:0] shx_q, shy_q;
  logic                   nx3_q, ny3_q;
  logic signed [SH_W-2:0] t_cx, t_sy, t_sx, t_cy;
  logic [K_W-1:0]         kk_d, a_xx_d, a_yy_d;

  always_comb begin
    t_cx   = trunc_q(pcx_q);
    t_sy   = trunc_q(psy_q);
    t_sx   = trunc_q(psx_q);
    t_cy   = trunc_q(pcy_q);
    kk_d   = K_W'(cc_q) + axx_q + ayy_q;
    a_xx_d = K_W'(cc_q) + ayy_q;
    a_yy_d = K_W'(cc_q) + axx_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kk_q   <= kk_d;
      a_xx_q <= a_xx_d[A_W-1:0];
      a_yy_q <= a_yy_d[A_W-1:0];
      a_xy_q <= axy_q[A_W-1:0];
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      shx_q  <= {t_cx[SH_W-2], t_cx} + {t_sy[SH_W-2], t_sy};
      shy_q  <= {t_sx[SH_W-2], t_sx} - {t_cy[SH_W-2], t_cy};
      nx3_q  <= nx2_q;
      ny3_q  <= ny2_q;
    end
  end

  // Valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root of K
  // --------------------------------------------------------------------------
  sqrt_side_t       sq_side_in, sq_side_out;
  logic             sq_v;
  logic [SQ_W-1:0]  sq_root;

  always_comb begin
    sq_side_in.kk        = kk_q;
    sq_side_in.a_xx      = a_xx_q;
    sq_side_in.a_yy      = a_yy_q;
    sq_side_in.a_xy      = a_xy_q;
    sq_side_in.ax        = ax3_q;
    sq_side_in.ay        = ay3_q;
    sq_side_in.fin.sh_x  = shx_q;
    sq_side_in.fin.sh_y  = shy_q;
    sq_side_in.fin.neg_x = nx3_q;
    sq_side_in.fin.neg_y = ny3_q;
    sq_side_in.fin.sing  = (kk_q == '0);
  end

  ilsd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .rad_i   (kk_q),
    .side_i  (sq_side_in),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side_out)
  );

  // --------------------------------------------------------------------------
  // Stage M1: partial products of numerators and denominator
  // --------------------------------------------------------------------------
  logic                          m1_v_q;
  logic [2*WORD_BITS-1:0]        pk_lo_q, pk_hi_q;
  logic [E_W+WORD_BITS-1:0]      pa_lo_q [3];
  logic [E_W+A_W-WORD_BITS-1:0]  pa_hi_q [3];
  logic [E_W+MAG_W-1:0]          eax_q, eay_q;
  logic [SQ_W-1:0]               sq1_q;
  fin_side_t                     fin1_q;
  logic [A_W-1:0]                a_sel [3];

  assign a_sel[0] = sq_side_out.a_xx;
  assign a_sel[1] = sq_side_out.a_xy;
  assign a_sel[2] = sq_side_out.a_yy;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pk_lo_q <= sq_side_out.kk[WORD_BITS-1:0] * sq_root;
      pk_hi_q <= sq_side_out.kk[K_W-1:WORD_BITS] * sq_root;
      for (int j = 0; j < 3; j++) begin
        pa_lo_q[j] <= einstein_q * a_sel[j][WORD_BITS-1:0];
        pa_hi_q[j] <= einstein_q * a_sel[j][A_W-1:WORD_BITS];
      end
      eax_q  <= einstein_q * sq_side_out.ax;
      eay_q  <= einstein_q * sq_side_out.ay;
      sq1_q  <= sq_root;
      fin1_q <= sq_side_out.fin;
    end
  end

  // --------------------------------------------------------------------------
  // Stage M2: assemble divider operands
  // --------------------------------------------------------------------------
  logic                        m2_v_q;
  logic [LANES-1:0][NUM_W-1:0] num_q;
  logic [LANES-1:0][DEN_W-1:0] den_q;
  fin_side_t                   fin2_q;
  logic [E_W+A_W-1:0]          ea [3];
  logic [DEN_W-1:0]            den_k;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ea[j] = {pa_hi_q[j], {WORD_BITS{1'b0}}}
            + {{(A_W-WORD_BITS){1'b0}}, pa_lo_q[j]};
    end
    den_k = {pk_hi_q, {WORD_BITS{1'b0}}} + {{WORD_BITS{1'b0}}, pk_lo_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q[L_DX] <= {{(NUM_W-E_W-MAG_W){1'b0}}, eax_q};
      num_q[L_DY] <= {{(NUM_W-E_W-MAG_W){1'b0}}, eay_q};
      num_q[L_XX] <= {ea[0], {FRAC_BITS{1'b0}}};
      num_q[L_XY] <= {ea[1], {FRAC_BITS{1'b0}}};
      num_q[L_YY] <= {ea[2], {FRAC_BITS{1'b0}}};
      den_q[L_DX] <= {{(DEN_W-SQ_W){1'b0}}, sq1_q};
      den_q[L_DY] <= {{(DEN_W-SQ_W){1'b0}}, sq1_q};
      den_q[L_XX] <= den_k;
      den_q[L_XY] <= den_k;
      den_q[L_YY] <= den_k;
      fin2_q      <= fin1_q;
    end
  end

  // Valid bits of the multiply stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= sq_v;
      m2_v_q <= m1_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // Five divisions in parallel lanes
  // --------------------------------------------------------------------------
  logic                      dv_v;
  logic [LANES-1:0][Q_W:0]   quo;
  fin_side_t                 dv_side;

  ilsd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m2_v_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (fin2_q),
    .valid_o (dv_v),
    .quo_o   (quo),
    .side_o  (dv_side)
  );

  // --------------------------------------------------------------------------
  // Stage F1: apply signs and add shear
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] res_q [LANES];
  logic signed [SUM_W-1:0] zq    [LANES];
  logic signed [SUM_W-1:0] c_ext, s_ext, shx_ext, shy_ext;
  logic                    sing1_q, neg_xy;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      zq[l] = {{(SUM_W-Q_W-1){1'b0}}, quo[l]};
    end
    c_ext   = {{(SUM_W-WORD_BITS){shear_cos_q[WORD_BITS-1]}}, shear_cos_q};
    s_ext   = {{(SUM_W-WORD_BITS){shear_sin_q[WORD_BITS-1]}}, shear_sin_q};
    shx_ext = {{(SUM_W-SH_W){dv_side.sh_x[SH_W-1]}}, dv_side.sh_x};
    shy_ext = {{(SUM_W-SH_W){dv_side.sh_y[SH_W-1]}}, dv_side.sh_y};
    neg_xy  = (dv_side.neg_x == dv_side.neg_y);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q[L_DX] <= (dv_side.neg_x ? -zq[L_DX] : zq[L_DX]) + shx_ext;
      res_q[L_DY] <= (dv_side.neg_y ? -zq[L_DY] : zq[L_DY]) + shy_ext;
      res_q[L_XX] <= zq[L_XX] + c_ext;
      res_q[L_XY] <= (neg_xy ? -zq[L_XY] : zq[L_XY]) + s_ext;
      res_q[L_YY] <= zq[L_YY] - c_ext;
      sing1_q     <= dv_side.sing;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: saturate, flag, hold while stalled
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] out_q [LANES];
  logic [WORD_BITS-1:0] sat_d [LANES];
  logic [1:0]           status_q, status_d;
  logic                 flag;

  always_comb begin
    flag = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (res_q[l] > SAT_HI) begin
        sat_d[l] = SAT_HI[WORD_BITS-1:0];
        flag     = 1'b1;
      end else if (res_q[l] < SAT_LO) begin
        sat_d[l] = SAT_LO[WORD_BITS-1:0];
        flag     = 1'b1;
      end else begin
        sat_d[l] = res_q[l][WORD_BITS-1:0];
      end
    end
    if (sing1_q) begin
      status_d = ST_SING;
    end else if (flag) begin
      status_d = ST_SAT;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      for (int l = 0; l < LANES; l++) begin
        out_q[l] <= sing1_q ? '0 : sat_d[l];
      end
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en) begin
        f1_v_q <= dv_v;
      end
      if (out_en) begin
        out_v_q <= f1_v_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign deflect_x_o = out_q[L_DX];
  assign deflect_y_o = out_q[L_DY];
  assign jac_xx_o    = out_q[L_XX];
  assign jac_xy_o    = out_q[L_XY];
  assign jac_yy_o    = out_q[L_YY];
  assign status_o    = status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ILSD_ASSERT(a_stall_src, !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without output stall")
  `ILSD_IMPLY(a_sing_zero, out_valid_o && status_o == ST_SING, deflect_x_o == '0 && deflect_y_o == '0 && jac_xx_o == '0 && jac_xy_o == '0 && jac_yy_o == '0, "singular result not zero")
  `ILSD_IMPLY(a_sat_bound, out_valid_o && status_o == ST_SAT, deflect_x_o == SAT_HI[WORD_BITS-1:0] || deflect_x_o == SAT_LO[WORD_BITS-1:0] || deflect_y_o == SAT_HI[WORD_BITS-1:0] || deflect_y_o == SAT_LO[WORD_BITS-1:0] || jac_xx_o == SAT_HI[WORD_BITS-1:0] || jac_xx_o == SAT_LO[WORD_BITS-1:0] || jac_xy_o == SAT_HI[WORD_BITS-1:0] || jac_xy_o == SAT_LO[WORD_BITS-1:0] || jac_yy_o == SAT_HI[WORD_BITS-1:0] || jac_yy_o == SAT_LO[WORD_BITS-1:0], "saturation flagged without clamped value")

endmodule

/* dv/isothermal_lens_shear_deflection_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isothermal_lens_shear_deflection_test
// Self-checking bench for the cored isothermal lens with shear.
//
// A queue of pending requests, register writes and drain markers feeds a
// clocked driver. Every accepted position is run through a bit-exact
// predictor of the deflection and Jacobian. The expected results are held
// in order and compared field by field with each accepted result. Both
// sides idle at random, the receiver stalls once long enough to back up
// the pipeline, and register settings change only while the block is empty.
// ----------------------------------------------------------------------------
module isothermal_lens_shear_deflection_test;
  import ilsd_pkg::*;

  localparam int LATENCY = 88;
  localparam logic [127:0] QUOT_LIMIT = 128'd1 << 60;

  typedef enum logic [1:0] {ACT_POS, ACT_CFG, ACT_DRAIN} act_e;

  typedef struct {
    act_e        kind;
    logic [31:0] a;
    logic [31:0] b;
  } action_t;

  typedef struct {
    logic signed [31:0] dfx;
    logic signed [31:0] dfy;
    logic signed [31:0] jxx;
    logic signed [31:0] jxy;
    logic signed [31:0] jyy;
    logic [1:0]         st;
  } lens_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [WORD_BITS-1:0]        cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic signed [WORD_BITS-1:0] pos_x_i = '0;
  logic signed [WORD_BITS-1:0] pos_y_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [WORD_BITS-1:0] deflect_x_o;
  logic signed [WORD_BITS-1:0] deflect_y_o;
  logic signed [WORD_BITS-1:0] jac_xx_o;
  logic signed [WORD_BITS-1:0] jac_xy_o;
  logic signed [WORD_BITS-1:0] jac_yy_o;
  logic [1:0]                  status_o;

  isothermal_lens_shear_deflection dut (.*);

  // Shadow copy of the lens registers
  logic [30:0]        core_r = 31'd0;
  logic [30:0]        ein_r  = 31'd65536;
  logic signed [31:0] cos_r  = '0;
  logic signed [31:0] sin_r  = '0;

  action_t   pending_q[$];
  lens_out_t lens_expect_q[$];
  int        n_requests = 0;
  int        n_results = 0;
  int        n_mismatch = 0;
  int        settle_cnt = 0;

  // Stall and pace of both sides
  function automatic bit quiet_window();
    return n_requests >= 700 && n_requests < 900;
  endfunction

  function automatic bit take_gap();
    return !quiet_window() && $urandom_range(99) < 36;
  endfunction

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic longint lens_slope(logic [63:0] numer, logic [63:0] kk,
                                        logic [63:0] root);
    logic [127:0] num, den, quo;
    num = ({97'd0, ein_r} * {64'd0, numer}) << FRAC_BITS;
    den = {64'd0, kk} * {64'd0, root};
    quo = num / den;
    if (quo > QUOT_LIMIT) quo = QUOT_LIMIT;
    return longint'(quo[63:0]);
  endfunction

  function automatic longint shear_part(logic signed [31:0] c, logic signed [31:0] v);
    longint prod;
    prod = longint'(c) * longint'(v);
    return prod / (longint'(1) << FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] clamp_word(longint v, ref bit hit);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -longint'(64'h8000_0000)) begin
      hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic lens_out_t predict_lens(logic signed [31:0] x, logic signed [31:0] y);
    lens_out_t   r;
    logic [63:0] ax, ay, cc, kk, root;
    longint      dx, dy, jo;
    bit          hit;
    ax = x < 0 ? 64'(-longint'(x)) : 64'(x);
    ay = y < 0 ? 64'(-longint'(y)) : 64'(y);
    cc = {33'd0, core_r} * {33'd0, core_r};
    kk = cc + ax * ax + ay * ay;
    r = '{0, 0, 0, 0, 0, ST_SING};
    hit = 1'b0;
    if (kk != 0) begin
      root = floor_sqrt(kk);
      dx = longint'(({33'd0, ein_r} * ax) / root);
      dy = longint'(({33'd0, ein_r} * ay) / root);
      jo = lens_slope(ax * ay, kk, root);
      if (x < 0) dx = -dx;
      if (y < 0) dy = -dy;
      // off-diagonal term opposes the sign of x*y
      if ((x < 0) == (y < 0)) jo = -jo;
      r.dfx = clamp_word(dx + shear_part(cos_r, x) + shear_part(sin_r, y), hit);
      r.dfy = clamp_word(dy + shear_part(sin_r, x) - shear_part(cos_r, y), hit);
      r.jxx = clamp_word(lens_slope(ay * ay + cc, kk, root) + cos_r, hit);
      r.jxy = clamp_word(jo + sin_r, hit);
      r.jyy = clamp_word(lens_slope(ax * ax + cc, kk, root) - cos_r, hit);
      r.st  = hit ? ST_SAT : ST_OK;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: requests, register writes and drain pauses
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    action_t head;
    bit      pos_hold, cfg_hold, next_pos, next_cfg;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      pos_hold = in_valid_i && !in_ready_o;
      cfg_hold = cfg_valid_i && !cfg_ready_o;
      next_pos = pos_hold;
      next_cfg = cfg_hold;
      // record accepted requests and register writes
      if (in_valid_i && in_ready_o) begin
        lens_expect_q.push_back(predict_lens(pos_x_i, pos_y_i));
        n_requests++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_CORE: core_r = cfg_data_i[30:0];
          REG_EIN:  ein_r  = cfg_data_i[30:0];
          REG_COS:  cos_r  = cfg_data_i;
          REG_SIN:  sin_r  = cfg_data_i;
          default: ;
        endcase
      end
      settle_cnt = (lens_expect_q.size() == 0 && !in_valid_i) ? settle_cnt + 1 : 0;
      // launch the next pending action
      if (!pos_hold && !cfg_hold && pending_q.size() > 0) begin
        head = pending_q[0];
        case (head.kind)
          ACT_POS: begin
            if (!take_gap()) begin
              pos_x_i  <= head.a;
              pos_y_i  <= head.b;
              next_pos = 1'b1;
              void'(pending_q.pop_front());
            end
          end
          ACT_CFG: begin
            if (settle_cnt > 4) begin
              cfg_index_i <= head.a[CFG_IDX_W-1:0];
              cfg_data_i  <= head.b;
              next_cfg = 1'b1;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            if (lens_expect_q.size() == 0) void'(pending_q.pop_front());
          end
        endcase
      end
      in_valid_i  <= next_pos;
      cfg_valid_i <= next_cfg;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver pacing, with one long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    int hold_cnt;
    bit hold_done;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && n_results >= 400) begin
        hold_done = 1'b1;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !take_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each result with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    lens_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (lens_expect_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = lens_expect_q.pop_front();
        if (deflect_x_o !== want.dfx || deflect_y_o !== want.dfy ||
            jac_xx_o !== want.jxx || jac_xy_o !== want.jxy ||
            jac_yy_o !== want.jyy || status_o !== want.st) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp %0d %0d %0d %0d %0d st%0d, got %0d %0d %0d %0d %0d st%0d",
                     want.dfx, want.dfy, want.jxx, want.jxy, want.jyy, want.st,
                     deflect_x_o, deflect_y_o, jac_xx_o, jac_xy_o, jac_yy_o, status_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic add_pos(logic [31:0] x, logic [31:0] y);
    pending_q.push_back('{ACT_POS, x, y});
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    pending_q.push_back('{ACT_CFG, 32'(idx), val});
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return 32'($urandom);
      1:       return '0;
      2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3, 4:    return 32'($signed(32'($urandom_range(32'h00FF_FFFF))) - 32'sh0080_0000);
      default: return 32'($signed(32'($urandom_range(32'h000F_FFFF))) - 32'sh0008_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_reg(bit signed_reg);
    case ($urandom_range(5))
      0:       return '0;
      1:       return signed_reg ? 32'h8000_0000 : 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'($urandom);
      default: return signed_reg ? 32'($signed(32'($urandom_range(32'h0003_FFFF))) -
                                       32'sh0002_0000)
                                 : 32'($urandom_range(32'h0004_0000));
    endcase
  endfunction

  initial begin
    // directed: reset settings, singular point and field extremes
    add_pos(32'h0, 32'h0);
    add_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_pos(32'h8000_0000, 32'h8000_0000);
    add_pos(32'h8000_0000, 32'h7FFF_FFFF);
    add_pos(32'h0001_0000, 32'h0);
    add_pos(32'h0, 32'hFFFF_0000);
    add_pos(32'hFFFF_FFFF, 32'h0000_0001);
    add_pos(32'h0001_0000, 32'h0001_0000);
    // wide register values keep only their low bits; shear at extremes
    add_cfg(REG_CORE, 32'hFFFF_FFFF);
    add_cfg(REG_EIN, 32'hFFFF_FFFF);
    add_cfg(REG_COS, 32'h8000_0000);
    add_cfg(REG_SIN, 32'h7FFF_FFFF);
    add_pos(32'h0, 32'h0);
    add_pos(32'h7FFF_FFFF, 32'h8000_0000);
    add_pos(32'h0000_0001, 32'hFFFF_FFFF);
    add_pos(32'h8000_0000, 32'h0);
    // tiny core, zero lens, shear only
    add_cfg(REG_CORE, 32'h0000_0001);
    add_cfg(REG_EIN, 32'h0);
    add_cfg(REG_COS, 32'h7FFF_FFFF);
    add_cfg(REG_SIN, 32'h8000_0000);
    add_pos(32'h0, 32'h0);
    add_pos(32'h0000_0001, 32'h0000_0001);
    add_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_pos(32'hFFFF_8000, 32'h0000_8000);
    // random phases, each with a fresh register setting
    for (int ph = 0; ph < 6; ph++) begin
      add_cfg(REG_CORE, $urandom_range(3) == 0 ? 32'h0 : pick_reg(1'b0));
      add_cfg(REG_EIN, pick_reg(1'b0));
      add_cfg(REG_COS, pick_reg(1'b1));
      add_cfg(REG_SIN, pick_reg(1'b1));
      for (int k = 0; k < 200; k++) begin
        if (ph == 2 && k == 100) pending_q.push_back('{ACT_DRAIN, '0, '0});
        add_pos(pick_coord(), pick_coord());
      end
    end
  end

  // ---------------------------------------------------------------------
  // Clock, reset, end of run
  // ---------------------------------------------------------------------
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    wait (!in_valid_i && !cfg_valid_i && lens_expect_q.size() == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (n_mismatch == 0 && lens_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
